[sv/csvtok_pkg.sv]
// Shared types and constants for the CSV field tokenizer.
package csvtok_pkg;

  localparam logic [7:0] CharQuote   = 8'h22;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] DelimReset  = 8'h2C;

  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCountW   = $clog2(QDepth + 1);

  // Classified input byte, as handed from front to back.
  typedef struct packed {
    logic [7:0] data_char;
    logic       end_of_file;
    logic       is_quote;
    logic       is_newline;
    logic       is_delim;
  } token_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] cell_char;
    logic       cell_end;
    logic       row_end;
  } result_t;

  // Queue status toward the producer and consumer sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_PLAIN  = 4'b0010,
    PH_QUOTED = 4'b0100,
    PH_QSEEN  = 4'b1000
  } phase_t;

endpackage

[sv/csvtok_if.sv]
// Channel interfaces: input bytes, result items and the delimiter write port.
interface csvtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_char;
  logic       end_of_file;

  modport source (output valid, output data_char, output end_of_file, input ready);
  modport sink   (input valid, input data_char, input end_of_file, output ready);
endinterface

interface csvtok_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] cell_char;
  logic       cell_end;
  logic       row_end;

  modport source (output valid, output has_char, output cell_char, output cell_end,
                  output row_end, input ready);
  modport sink   (input valid, input has_char, input cell_char, input cell_end,
                  input row_end, output ready);
endinterface

interface csvtok_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/csvtok_front.sv]
// Front end: delimiter register and byte classification into tokens.
module csvtok_front import csvtok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  logic [7:0] data_char,
  input  logic       end_of_file,
  output token_t     token
);

  logic [7:0] delimiter;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DelimReset;
    end else if (cfg_valid) begin
      delimiter <= cfg_data;
    end
  end

  always_comb begin
    token.data_char   = data_char;
    token.end_of_file = end_of_file;
    token.is_quote    = (data_char == CharQuote);
    token.is_newline  = (data_char == CharNewline);
    token.is_delim    = (data_char == delimiter);
  end

endmodule

[sv/csvtok_queue.sv]
// Small token queue between front and back.
module csvtok_queue import csvtok_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  token_t    push_token,
  input  logic      pop,
  output token_t    pop_token,
  output q_status_t status
);

  token_t             store [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCountW-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == QCountW'(QDepth));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_token    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= QPtrW'((QPtrW+1)'(wr_ptr) + 1'b1);
      if (do_pop)  rd_ptr <= QPtrW'((QPtrW+1)'(rd_ptr) + 1'b1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/csvtok_back.sv]
// Back end: cell/row state machine and the result output register.
module csvtok_back import csvtok_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tok_valid,
  input  token_t  tok,
  output logic    tok_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  phase_t  phase, phase_next;
  logic    row_open, row_open_next;
  logic    res_valid;
  result_t res;

  assign tok_pop = tok_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next    = phase;
    row_open_next = row_open;
    res_valid     = 1'b0;
    res           = '0;
    if (tok.end_of_file) begin
      phase_next    = PH_START;
      row_open_next = 1'b0;
      if (phase != PH_START) begin
        res_valid    = 1'b1;
        res.cell_end = 1'b1;
        res.row_end  = 1'b1;
      end else if (row_open) begin
        res_valid   = 1'b1;
        res.row_end = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_START: begin
          row_open_next = 1'b1;
          // quote wins over a delimiter that equals the quote
          if (tok.is_quote) begin
            phase_next = PH_QUOTED;
          end else if (tok.is_delim || tok.is_newline) begin
            row_open_next = !tok.is_newline;
            res_valid     = 1'b1;
            res.cell_end  = 1'b1;
            res.row_end   = tok.is_newline;
          end else begin
            phase_next    = PH_PLAIN;
            res_valid     = 1'b1;
            res.has_char  = 1'b1;
            res.cell_char = tok.data_char;
          end
        end
        PH_PLAIN: begin
          if (tok.is_delim || tok.is_newline) begin
            phase_next    = PH_START;
            row_open_next = !tok.is_newline;
            res_valid     = 1'b1;
            res.cell_end  = 1'b1;
            res.row_end   = tok.is_newline;
          end else begin
            res_valid     = 1'b1;
            res.has_char  = 1'b1;
            res.cell_char = tok.data_char;
          end
        end
        PH_QUOTED: begin
          if (tok.is_quote) begin
            phase_next = PH_QSEEN;
          end else begin
            res_valid     = 1'b1;
            res.has_char  = 1'b1;
            res.cell_char = tok.data_char;
          end
        end
        PH_QSEEN: begin
          if (tok.is_quote) begin
            // doubled quote
            phase_next    = PH_QUOTED;
            res_valid     = 1'b1;
            res.has_char  = 1'b1;
            res.cell_char = CharQuote;
          end else begin
            // closing quote; this byte ends the cell and is dropped
            phase_next    = PH_START;
            row_open_next = !tok.is_newline;
            res_valid     = 1'b1;
            res.cell_end  = 1'b1;
            res.row_end   = tok.is_newline;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      row_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase    <= phase_next;
        row_open <= row_open_next;
      end
      if (tok_pop && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && res_valid) begin
      out_res <= res;
    end
  end

endmodule

[sv/csv_field_tokenizer_core.sv]
// Top level of the CSV field tokenizer.
//
//   channel | dir | payload                                   | transfer
//   src     | in  | data_char[8], end_of_file                 | valid && ready
//   dst     | out | has_char, cell_char[8], cell_end, row_end | valid && ready
//   cfg     | in  | data[8] = delimiter_char                  | valid && ready
//
// One byte per cycle sustained while dst keeps ready high; a result leaves from the back
// end's output register in the cycle after its byte leaves the 4-entry token queue.
// src.ready drops only when the queue is full behind a stalled dst.
// cfg.ready is always high. Reset (rst, synchronous) restores the comma
// delimiter and the cell-start state; no clearing pass is needed.
module csv_field_tokenizer_core import csvtok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  csvtok_in_if.sink  src,
  csvtok_out_if.source dst,
  csvtok_cfg_if.sink cfg
);

  token_t    front_tok;
  token_t    back_tok;
  q_status_t q_status;
  logic      tok_pop;
  result_t   out_res;

  assign cfg.ready = 1'b1;
  assign src.ready = !q_status.full;

  csvtok_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg.valid),
    .cfg_data    (cfg.data),
    .data_char   (src.data_char),
    .end_of_file (src.end_of_file),
    .token       (front_tok)
  );

  csvtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (src.valid),
    .push_token (front_tok),
    .pop        (tok_pop),
    .pop_token  (back_tok),
    .status     (q_status)
  );

  csvtok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!q_status.empty),
    .tok       (back_tok),
    .tok_pop   (tok_pop),
    .out_valid (dst.valid),
    .out_ready (dst.ready),
    .out_res   (out_res)
  );

  assign dst.has_char  = out_res.has_char;
  assign dst.cell_char = out_res.cell_char;
  assign dst.cell_end  = out_res.cell_end;
  assign dst.row_end   = out_res.row_end;

endmodule

[sv/csvtok_checker.sv]
// Port-level checks for the CSV field tokenizer, bound to the top level.
module csvtok_checker (
  input logic       clk,
  input logic       rst,
  input logic       src_ready,
  input logic       dst_valid,
  input logic       dst_ready,
  input logic       dst_has_char,
  input logic [7:0] dst_cell_char,
  input logic       dst_cell_end,
  input logic       dst_row_end
);

  // nothing leaves the block in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid right after reset");

  // input stalls only when the output has been held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(src_ready) |-> $past(dst_valid && !dst_ready))
    else $error("input stalled without output backpressure");

  // a cell byte never carries end marks
  a_char_alone: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_has_char |-> !dst_cell_end && !dst_row_end)
    else $error("cell byte combined with end marks");

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_has_char)
      && $stable(dst_cell_char) && $stable(dst_cell_end) && $stable(dst_row_end))
    else $error("stalled result changed");

endmodule

bind csv_field_tokenizer_core csvtok_checker u_csvtok_checker (
  .clk           (clk),
  .rst           (rst),
  .src_ready     (src.ready),
  .dst_valid     (dst.valid),
  .dst_ready     (dst.ready),
  .dst_has_char  (dst.has_char),
  .dst_cell_char (dst.cell_char),
  .dst_cell_end  (dst.cell_end),
  .dst_row_end   (dst.row_end)
);

[bench/csvtok_cell_checker.sv]
// Watches the tokenizer channels, predicts each cell result and compares it.
`timescale 1ns / 1ps

module csvtok_cell_checker import csvtok_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  csvtok_in_if  in_ch,
  csvtok_out_if out_ch,
  csvtok_cfg_if cfg_ch,
  input  logic  end_check,
  output int    pending,
  output int    mismatches,
  output int    results_seen
);

  phase_t     phase_q;
  logic       row_open_q;
  logic [7:0] delim_q;
  result_t    cells_due[$];

  initial begin
    pending      = 0;
    mismatches   = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Advances the parser copy by one byte; returns 1 when a result is due.
  function automatic bit tokenize_byte(input logic [7:0] c, input logic eof,
                                       output result_t res);
    bit nl;
    bit dl;
    bit got;
    nl  = (c == CharNewline);
    dl  = (c == delim_q);
    got = 1'b0;
    res = '0;
    if (eof) begin
      // trailing empty cell is not emitted; row closes only if it holds cells
      if (phase_q != PH_START) begin
        res.cell_end = 1'b1;
        res.row_end  = 1'b1;
        got = 1'b1;
      end else if (row_open_q) begin
        res.row_end = 1'b1;
        got = 1'b1;
      end
      phase_q    = PH_START;
      row_open_q = 1'b0;
      return got;
    end
    case (phase_q)
      PH_START: begin
        if (c == CharQuote) begin
          phase_q    = PH_QUOTED;
          row_open_q = 1'b1;
        end else if (dl || nl) begin
          row_open_q   = !nl;
          res.cell_end = 1'b1;
          res.row_end  = nl;
          got = 1'b1;
        end else begin
          phase_q       = PH_PLAIN;
          row_open_q    = 1'b1;
          res.has_char  = 1'b1;
          res.cell_char = c;
          got = 1'b1;
        end
      end
      PH_PLAIN: begin
        if (dl || nl) begin
          phase_q      = PH_START;
          row_open_q   = !nl;
          res.cell_end = 1'b1;
          res.row_end  = nl;
        end else begin
          res.has_char  = 1'b1;
          res.cell_char = c;
        end
        got = 1'b1;
      end
      PH_QUOTED: begin
        if (c == CharQuote) begin
          phase_q = PH_QSEEN;
        end else begin
          res.has_char  = 1'b1;
          res.cell_char = c;
          got = 1'b1;
        end
      end
      default: begin
        // quote seen: a second quote is literal, anything else closes the cell
        if (c == CharQuote) begin
          phase_q       = PH_QUOTED;
          res.has_char  = 1'b1;
          res.cell_char = CharQuote;
        end else begin
          phase_q      = PH_START;
          row_open_q   = !nl;
          res.cell_end = 1'b1;
          res.row_end  = nl;
        end
        got = 1'b1;
      end
    endcase
    return got;
  endfunction

  always @(posedge clk) begin : watch
    result_t due;
    result_t want;
    if (rst) begin
      phase_q    = PH_START;
      row_open_q = 1'b0;
      delim_q    = DelimReset;
      cells_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) delim_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (tokenize_byte(in_ch.data_char, in_ch.end_of_file, due)) cells_due.push_back(due);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (cells_due.size() == 0) begin
          report_mismatch("unexpected result", out_ch.cell_char, 8'h00);
        end else begin
          want = cells_due.pop_front();
          if (out_ch.has_char !== want.has_char)
            report_mismatch("has_char", 8'(out_ch.has_char), 8'(want.has_char));
          if (out_ch.cell_char !== want.cell_char)
            report_mismatch("cell_char", out_ch.cell_char, want.cell_char);
          if (out_ch.cell_end !== want.cell_end)
            report_mismatch("cell_end", 8'(out_ch.cell_end), 8'(want.cell_end));
          if (out_ch.row_end !== want.row_end)
            report_mismatch("row_end", 8'(out_ch.row_end), 8'(want.row_end));
        end
      end
      if (end_check) begin
        while (cells_due.size() > 0) begin
          want = cells_due.pop_front();
          report_mismatch("missing result", 8'h00, want.cell_char);
        end
      end
    end
    pending = cells_due.size();
  end

endmodule

[bench/testbench.sv]
// Stimulus and verdict for the CSV field tokenizer core.
`timescale 1ns / 1ps

module testbench;
  import csvtok_pkg::*;

  logic clk;
  logic rst;
  logic end_check;
  logic no_idle;
  int   pending;
  int   mismatches;
  int   results_seen;
  int   items_sent;
  int   delim_writes;
  logic [7:0] delim_now;

  csvtok_in_if  in_ch ();
  csvtok_out_if out_ch ();
  csvtok_cfg_if cfg_ch ();

  csv_field_tokenizer_core dut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch),
    .cfg (cfg_ch)
  );

  csvtok_cell_checker cell_chk (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .end_check    (end_check),
    .pending      (pending),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 27);
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_item(input logic [7:0] c, input logic eof);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_char   <= c;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // eof with random data: the byte is ignored but its bits still toggle
  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Lets queued results and resultless bytes clear; bounded so a lost result ends up reported.
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic write_delim(input logic [7:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    delim_now = d;
    delim_writes++;
  endtask

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 9))
      0, 1:    return CharQuote;
      2:       return delim_now;
      3:       return CharNewline;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Byte that keeps an unquoted cell open; a quote may not lead the cell.
  function automatic logic [7:0] plain_byte(input bit lead);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? CharQuote : 8'($urandom_range(0, 255));
    end while (c == delim_now || c == CharNewline || (lead && c == CharQuote));
    return c;
  endfunction

  task automatic send_cell();
    int len;
    logic [7:0] c;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      send_item(CharQuote, 1'b0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_item(CharQuote, 1'b0);
          send_item(CharQuote, 1'b0);
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == CharQuote);
          send_item(c, 1'b0);
        end
      end
      send_item(CharQuote, 1'b0);
      // stray byte after the closing quote
      if ($urandom_range(0, 6) == 0) begin
        do c = 8'($urandom_range(0, 255)); while (c == CharQuote);
        send_item(c, 1'b0);
      end
    end else begin
      for (int i = 0; i < len; i++) send_item(plain_byte(i == 0), 1'b0);
    end
  endtask

  task automatic send_row();
    int cells;
    cells = $urandom_range(1, 4);
    for (int i = 0; i < cells; i++) begin
      send_cell();
      if (i < cells - 1) send_item(delim_now, 1'b0);
    end
    if ($urandom_range(0, 6) == 0) send_eof();
    else send_item(CharNewline, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_eof();
      else send_item(noisy_byte(), 1'b0);
    end
  endtask

  task automatic feed_rows(input int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) send_row();
      else send_noise();
    end
  endtask

  initial begin
    logic [7:0] delim_plan[8];
    delim_plan = '{8'h22, 8'h0A, 8'h00, 8'hFF, 8'h09, 8'h00, 8'h3B, DelimReset};
    delim_plan[5] = 8'($urandom_range(0, 255));
    rst               = 1'b1;
    end_check         = 1'b0;
    no_idle           = 1'b0;
    items_sent        = 0;
    delim_writes      = 0;
    delim_now         = DelimReset;
    in_ch.valid       = 1'b0;
    in_ch.data_char   = 8'h00;
    in_ch.end_of_file = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 8'h00;
    out_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: plain and empty cells, quoted cells with doubled quote and stray bytes
    send_text("a,b\n");
    send_text(",\n");
    send_text("\"x\"\"\",");
    send_text("\"\"z");
    send_text("q\"");
    send_eof();
    send_text("\"\"\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text(",");
    send_eof();
    send_eof();
    send_text("\"a");
    send_eof();

    feed_rows(100);
    foreach (delim_plan[i]) begin
      wait_drained();
      write_delim(delim_plan[i]);
      no_idle = (i == 2);
      feed_rows(90);
    end
    no_idle = 1'b0;

    wait_drained();
    @(negedge clk);
    end_check <= 1'b1;
    @(negedge clk);
    end_check <= 1'b0;
    @(negedge clk);
    $display("Sent %0d bytes and end marks under %0d delimiter settings.",
             items_sent, delim_writes + 1);
    $display("Checked %0d cell results; %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
